/* rtl/rqs_pkg.sv */
// Shared types, widths and codes for the reading qualifier with statistics and queue.
package rqs_pkg;

   // Field widths
   localparam int LUX_W    = 24;
   localparam int CNT_W    = 32;
   localparam int QUAL_W   = 8;
   localparam int STAMP_W  = 32;
   localparam int RAW_W    = 16;
   localparam int VOLT_W   = 16;
   localparam int LEVEL_W  = 6;
   localparam int STATUS_W = 3;

   // Running mean arithmetic: product of mean and count, then sum with lux
   localparam int PROD_W = LUX_W + CNT_W;
   localparam int SUM_W  = PROD_W + 1;

   // Configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;

   localparam logic [CSR_IDX_W-1:0] CSR_MIN_LUX     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_LUX     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_QUALITY = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FLUSH_LEVEL = 2'd3;

   // Register reset values
   localparam logic [LUX_W-1:0]   MIN_LUX_RST     = '0;
   localparam logic [LUX_W-1:0]   MAX_LUX_RST     = '1;
   localparam logic [QUAL_W-1:0]  MIN_QUALITY_RST = '0;
   localparam logic [LEVEL_W-1:0] FLUSH_LEVEL_RST = 6'd16;

   // Default queue depth
   localparam int QUEUE_DEPTH_DEF = 32;

   // Result status codes
   localparam logic [STATUS_W-1:0] ST_ACCEPTED = 3'd0;
   localparam logic [STATUS_W-1:0] ST_FILTERED = 3'd1;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW = 3'd2;
   localparam logic [STATUS_W-1:0] ST_FLUSHED  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_DRAINED  = 3'd4;

   // Request kinds
   localparam logic KIND_READING = 1'b0;
   localparam logic KIND_FLUSH   = 1'b1;

   // Request payload
   typedef struct packed {
      logic                kind;
      logic                valid_req;
      logic [LUX_W-1:0]    lux;
      logic [QUAL_W-1:0]   quality;
      logic [STAMP_W-1:0]  stamp_ms;
      logic [RAW_W-1:0]    raw_count;
      logic [VOLT_W-1:0]   voltage_mv;
   } req_type;

   // Result payload
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [STAMP_W-1:0]  out_stamp_ms;
      logic [RAW_W-1:0]    out_raw;
      logic [LUX_W-1:0]    out_lux;
      logic [VOLT_W-1:0]   out_voltage_mv;
      logic [QUAL_W-1:0]   out_quality;
      logic [CNT_W-1:0]    accepted_total;
      logic [CNT_W-1:0]    filtered_total;
      logic [CNT_W-1:0]    overflow_total;
      logic [LUX_W-1:0]    lux_low;
      logic [LUX_W-1:0]    lux_high;
      logic [LUX_W-1:0]    lux_mean;
   } rsp_type;

   // One queued reading
   typedef struct packed {
      logic [STAMP_W-1:0] stamp_ms;
      logic [RAW_W-1:0]   raw_count;
      logic [LUX_W-1:0]   lux;
      logic [VOLT_W-1:0]  voltage_mv;
      logic [QUAL_W-1:0]  quality;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

/* rtl/rqs_ram.sv */
// Generic single write port, single read port RAM with registered read data.
module rqs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read, held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/rqs_div.sv */
// Restoring serial divider for the running mean, one quotient bit per cycle.
module rqs_div import rqs_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [SUM_W-1:0] dividend,
   input  logic [CNT_W-1:0] divisor,
   output logic             done,
   output logic [LUX_W-1:0] quotient
);

   localparam int STEP_W = $clog2(LUX_W);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(LUX_W - 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [LUX_W-1:0]  quo_ff, quo_in;
   logic [CNT_W-1:0]  dsr_ff, dsr_in;

   logic [CNT_W:0]    trial;
   logic [CNT_W:0]    diff;
   logic              fits;

   // Trial subtraction; the quotient is known to fit LUX_W bits, so the
   // upper part of the dividend is already below the divisor
   assign trial = {rem_ff, quo_ff[LUX_W-1]};
   assign diff  = trial - {1'b0, dsr_ff};
   assign fits  = trial >= {1'b0, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = dividend[SUM_W-2:LUX_W];
         quo_in  = dividend[LUX_W-1:0];
         dsr_in  = divisor;
      end else if (busy_ff) begin
         rem_in  = fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
         quo_in  = {quo_ff[LUX_W-2:0], fits};
         step_in = step_ff + 1'b1;
         if (step_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

/* rtl/reading_qualifier_stats_queue.sv */
// Top level: reading filter, statistics, drain queue and result sequencer.
// Filtered or overflow: result load after accept; empty flush: drain check first.
// Accepted reading: product at accept, sum, divide, mean load, final status.
// Each drained reading adds a queue RAM read, then a result load.
// One request at a time; stall stays high until the request's final result is loaded.
// Reset is synchronous: control, statistics and configuration clear; queue RAM is kept.
module reading_qualifier_stats_queue import rqs_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(QUEUE_DEPTH);

   // Sequencer states
   localparam logic [2:0] S_IDLE      = 3'd0;
   localparam logic [2:0] S_SUM       = 3'd1;
   localparam logic [2:0] S_DIV       = 3'd2;
   localparam logic [2:0] S_DRAIN_RD  = 3'd3;
   localparam logic [2:0] S_DRAIN_OUT = 3'd4;
   localparam logic [2:0] S_FINAL     = 3'd5;

   // Configuration registers
   logic [LUX_W-1:0]   min_lux_ff, min_lux_in;
   logic [LUX_W-1:0]   max_lux_ff, max_lux_in;
   logic [QUAL_W-1:0]  min_qual_ff, min_qual_in;
   logic [LEVEL_W-1:0] flush_lvl_ff, flush_lvl_in;

   // Control and statistics
   logic [2:0]         state_ff, state_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [OCC_W-1:0]   occ_ff, occ_in;
   logic [CNT_W-1:0]   acc_cnt_ff, acc_cnt_in;
   logic [CNT_W-1:0]   filt_cnt_ff, filt_cnt_in;
   logic [CNT_W-1:0]   ovf_cnt_ff, ovf_cnt_in;
   logic [LUX_W-1:0]   lux_min_ff, lux_min_in;
   logic [LUX_W-1:0]   lux_max_ff, lux_max_in;
   logic [LUX_W-1:0]   lux_avg_ff, lux_avg_in;
   logic               out_valid_ff, out_valid_in;

   // Payload registers
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [LUX_W-1:0]    lux_ff, lux_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   rsp_type             out_data_ff, out_data_in;

   // Handshake and decode
   logic               req_take;
   logic               slot_free;
   logic               passes;
   logic               drain_due;
   logic               div_start;
   logic [SUM_W-1:0]   div_dividend;
   logic               div_done;
   logic [LUX_W-1:0]   div_quotient;
   logic               ram_we;
   logic               ram_re;
   entry_type          ram_wdata;
   logic [ENTRY_W-1:0] ram_rdata;
   entry_type          rd_entry;

   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign slot_free = !out_valid_ff || !rsp_stall;

   // Filter window and quality check
   assign passes = req_data.valid_req && (req_data.lux >= min_lux_ff) &&
                   (req_data.lux <= max_lux_ff) && (req_data.quality >= min_qual_ff);

   assign drain_due = LEVEL_W'(occ_ff) >= flush_lvl_ff;

   // Queue entry written on an accepted reading
   assign ram_wdata.stamp_ms   = req_data.stamp_ms;
   assign ram_wdata.raw_count  = req_data.raw_count;
   assign ram_wdata.lux        = req_data.lux;
   assign ram_wdata.voltage_mv = req_data.voltage_mv;
   assign ram_wdata.quality    = req_data.quality;
   assign rd_entry             = entry_type'(ram_rdata);

   assign div_dividend = SUM_W'(prod_ff) + SUM_W'(lux_ff);

   // Configuration writes
   always_comb begin
      min_lux_in   = min_lux_ff;
      max_lux_in   = max_lux_ff;
      min_qual_in  = min_qual_ff;
      flush_lvl_in = flush_lvl_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_MIN_LUX:     min_lux_in   = csr_wdata[LUX_W-1:0];
            CSR_MAX_LUX:     max_lux_in   = csr_wdata[LUX_W-1:0];
            CSR_MIN_QUALITY: min_qual_in  = csr_wdata[QUAL_W-1:0];
            CSR_FLUSH_LEVEL: flush_lvl_in = csr_wdata[LEVEL_W-1:0];
            default: ;
         endcase
      end
   end

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      rd_ptr_in    = rd_ptr_ff;
      wr_ptr_in    = wr_ptr_ff;
      occ_in       = occ_ff;
      acc_cnt_in   = acc_cnt_ff;
      filt_cnt_in  = filt_cnt_ff;
      ovf_cnt_in   = ovf_cnt_ff;
      lux_min_in   = lux_min_ff;
      lux_max_in   = lux_max_ff;
      lux_avg_in   = lux_avg_ff;
      status_in    = status_ff;
      lux_in       = lux_ff;
      prod_in      = prod_ff;
      out_data_in  = out_data_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      ram_we       = 1'b0;
      ram_re       = 1'b0;
      div_start    = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               if (req_data.kind == KIND_FLUSH) begin
                  status_in = ST_FLUSHED;
                  state_in  = S_DRAIN_RD;
               end else if (!passes) begin
                  filt_cnt_in = filt_cnt_ff + 1'b1;
                  status_in   = ST_FILTERED;
                  state_in    = S_FINAL;
               end else if (occ_ff >= OCC_FULL) begin
                  ovf_cnt_in = ovf_cnt_ff + 1'b1;
                  status_in  = ST_OVERFLOW;
                  state_in   = S_FINAL;
               end else begin
                  // queue the reading and update the statistics
                  ram_we     = 1'b1;
                  wr_ptr_in  = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
                  occ_in     = occ_ff + 1'b1;
                  acc_cnt_in = acc_cnt_ff + 1'b1;
                  if (lux_min_ff == '0 || req_data.lux < lux_min_ff) begin
                     lux_min_in = req_data.lux;
                  end
                  if (req_data.lux > lux_max_ff) begin
                     lux_max_in = req_data.lux;
                  end
                  // mean times previous count
                  prod_in   = PROD_W'(lux_avg_ff) * PROD_W'(acc_cnt_ff);
                  lux_in    = req_data.lux;
                  status_in = ST_ACCEPTED;
                  state_in  = S_SUM;
               end
            end
         end
         S_SUM: begin
            if (acc_cnt_ff == '0) begin
               // count wrapped: mean restarts at this lux
               lux_avg_in = lux_ff;
               state_in   = drain_due ? S_DRAIN_RD : S_FINAL;
            end else begin
               div_start = 1'b1;
               state_in  = S_DIV;
            end
         end
         S_DIV: begin
            if (div_done) begin
               lux_avg_in = div_quotient;
               state_in   = drain_due ? S_DRAIN_RD : S_FINAL;
            end
         end
         S_DRAIN_RD: begin
            if (occ_ff == '0) begin
               state_in = S_FINAL;
            end else begin
               ram_re    = 1'b1;
               rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
               occ_in    = occ_ff - 1'b1;
               state_in  = S_DRAIN_OUT;
            end
         end
         S_DRAIN_OUT: begin
            if (slot_free) begin
               out_valid_in               = 1'b1;
               out_data_in.status         = ST_DRAINED;
               out_data_in.out_stamp_ms   = rd_entry.stamp_ms;
               out_data_in.out_raw        = rd_entry.raw_count;
               out_data_in.out_lux        = rd_entry.lux;
               out_data_in.out_voltage_mv = rd_entry.voltage_mv;
               out_data_in.out_quality    = rd_entry.quality;
               out_data_in.accepted_total = acc_cnt_ff;
               out_data_in.filtered_total = filt_cnt_ff;
               out_data_in.overflow_total = ovf_cnt_ff;
               out_data_in.lux_low        = lux_min_ff;
               out_data_in.lux_high       = lux_max_ff;
               out_data_in.lux_mean       = lux_avg_ff;
               state_in                   = S_DRAIN_RD;
            end
         end
         S_FINAL: begin
            if (slot_free) begin
               out_valid_in               = 1'b1;
               out_data_in.status         = status_ff;
               out_data_in.out_stamp_ms   = '0;
               out_data_in.out_raw        = '0;
               out_data_in.out_lux        = '0;
               out_data_in.out_voltage_mv = '0;
               out_data_in.out_quality    = '0;
               out_data_in.accepted_total = acc_cnt_ff;
               out_data_in.filtered_total = filt_cnt_ff;
               out_data_in.overflow_total = ovf_cnt_ff;
               out_data_in.lux_low        = lux_min_ff;
               out_data_in.lux_high       = lux_max_ff;
               out_data_in.lux_mean       = lux_avg_ff;
               state_in                   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control and statistics registers
   always_ff @(posedge clock) begin
      if (reset) begin
         min_lux_ff   <= MIN_LUX_RST;
         max_lux_ff   <= MAX_LUX_RST;
         min_qual_ff  <= MIN_QUALITY_RST;
         flush_lvl_ff <= FLUSH_LEVEL_RST;
         state_ff     <= S_IDLE;
         rd_ptr_ff    <= '0;
         wr_ptr_ff    <= '0;
         occ_ff       <= '0;
         acc_cnt_ff   <= '0;
         filt_cnt_ff  <= '0;
         ovf_cnt_ff   <= '0;
         lux_min_ff   <= '0;
         lux_max_ff   <= '0;
         lux_avg_ff   <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         min_lux_ff   <= min_lux_in;
         max_lux_ff   <= max_lux_in;
         min_qual_ff  <= min_qual_in;
         flush_lvl_ff <= flush_lvl_in;
         state_ff     <= state_in;
         rd_ptr_ff    <= rd_ptr_in;
         wr_ptr_ff    <= wr_ptr_in;
         occ_ff       <= occ_in;
         acc_cnt_ff   <= acc_cnt_in;
         filt_cnt_ff  <= filt_cnt_in;
         ovf_cnt_ff   <= ovf_cnt_in;
         lux_min_ff   <= lux_min_in;
         lux_max_ff   <= lux_max_in;
         lux_avg_ff   <= lux_avg_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      status_ff   <= status_in;
      lux_ff      <= lux_in;
      prod_ff     <= prod_in;
      out_data_ff <= out_data_in;
   end

   // Queue storage
   rqs_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wr_ptr_ff),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (rd_ptr_ff),
      .rd_data (ram_rdata)
   );

   // Running mean divider
   rqs_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (acc_cnt_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

`ifndef SYNTH
   // Occupancy never exceeds the queue depth
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= OCC_FULL)
      else $error("queue occupancy above depth");

   // An empty queue has its pointers together
   a_ptr_empty: assert property (@(posedge clock) disable iff (reset)
      (occ_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("pointers apart on empty queue");

   // A flush request goes straight to the drain
   a_flush_drain: assert property (@(posedge clock) disable iff (reset)
      (req_take && req_data.kind == KIND_FLUSH) |=> (state_ff == S_DRAIN_RD))
      else $error("flush request did not start a drain");

   // The divider only reports completion while the sequencer waits for it
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_DIV))
      else $error("divider finished outside its wait state");
`endif

endmodule
